### src/lhtf_pkg.sv
package lhtf_pkg;

  // Letter buffer of a backslash command
  localparam int CMD_CHARS = 10;
  localparam int LEN_W     = $clog2(CMD_CHARS + 1);
  localparam int LIDX_W    = $clog2(CMD_CHARS);

  // Brace depth saturation
  localparam int MAX_BRACE_DEPTH = 255;
  localparam int DEPTH_W         = $clog2(MAX_BRACE_DEPTH + 1);

  // Output bytes per input word: four spaces plus the letters at most
  localparam int CNT_W = $clog2(4 + CMD_CHARS + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_M   = 8'h6d;
  localparam logic [7:0] CH_LC_T   = 8'h74;

  // SGR codes
  localparam logic [7:0] SGR_UNDERLINE = 8'h34;
  localparam logic [7:0] SGR_REVERSE   = 8'h37;
  localparam logic [7:0] SGR_BOLD      = 8'h31;
  localparam logic [7:0] SGR_FINAL     = 8'h6d;

  typedef struct packed {
    logic load;   // take the input word, plan its output run
    logic step;   // one output word was taken
  } ctl_cmd_t;

  typedef struct packed {
    logic emits;  // the word being loaded produces output
    logic last;   // current output word ends the run
  } ctl_sts_t;

endpackage

### src/latex_help_text_filter.sv
// Help-entry text filter: turns the markup of a help entry into terminal text.
//
// Input channel (in_valid_i / in_ready_o / in_byte_i) takes one raw byte per
// word. Bytes before the first open brace are consumed silently. Output channel
// (out_valid_o / out_ready_i / out_byte_o, last_of_run_o, end_of_text_o)
// delivers the converted bytes; last_of_run_o marks the final byte caused by
// one input word, end_of_text_o the zero terminator that closes an entry.
//
// Flow: a word that produces no output only updates the filter state. A word that
// produces k bytes (k from 1 to 14: four spaces plus up to CMD_CHARS command
// letters) is first loaded and its run planned in the datapath, then its bytes
// leave one per cycle, selected from the registered run state, while
// out_ready_i is high. The run sequencer is the limit: no new word is taken
// until the last byte of the current run has been taken.
//
// Reset: the filter seeks an open brace, depth 1, no command or emphasis open.
// The command letter buffer is not cleared; only letters of the current
// command are ever read. A stall on out_ready_i holds the output byte and
// keeps in_ready_o low until the run drains.
module latex_help_text_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       end_of_text_o
);

  lhtf_pkg::ctl_cmd_t cmd;
  lhtf_pkg::ctl_sts_t sts;

  // Sequencer: load a word, then drain its run
  lhtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Filter state, letter buffer and run byte select
  lhtf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_byte_i     (in_byte_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .end_of_text_o (end_of_text_o)
  );

  // Input is only taken while no run is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while output run pending");

  // Terminator always closes its run
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_text_o) |-> last_of_run_o)
    else $error("terminator not at end of run");

  // Draining the final byte frees the input side
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_run_o) |=> (in_ready_o && !out_valid_o))
    else $error("block not idle after last byte");

  // A run continues until its last byte
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=> out_valid_o)
    else $error("run ended early");

endmodule

### src/lhtf_ctrl.sv
module lhtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lhtf_pkg::ctl_sts_t sts_i,
  output lhtf_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.step  = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && sts_i.emits) begin
            state_q     <= ST_EMIT;
            out_valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready_i && sts_i.last) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/lhtf_dp.sv
module lhtf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lhtf_pkg::ctl_cmd_t cmd_i,
  output lhtf_pkg::ctl_sts_t sts_o,
  input  logic [7:0]         in_byte_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o,
  output logic               end_of_text_o
);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ONE,
    OP_SPACE3,
    OP_SGR,
    OP_END,
    OP_END_TERM,
    OP_TERM,
    OP_BRACKET
  } op_e;

  // Filter state
  logic                         inside_q, inside_d;
  logic [lhtf_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic                         cmd_q, cmd_d;
  logic                         kanji_q, kanji_d;
  logic [1:0]                   tail_q, tail_d;
  logic                         brk_q, brk_d;
  logic                         emph_q, emph_d;
  logic [lhtf_pkg::LEN_W-1:0]   len_q, len_d;
  logic [7:0]                   letters_q [lhtf_pkg::CMD_CHARS];
  logic                         lt_we;

  // Output run
  op_e                          op_q, op_d;
  logic [7:0]                   arg_q, arg_d;
  logic [lhtf_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [lhtf_pkg::CNT_W-1:0]   idx_q;
  logic [lhtf_pkg::CNT_W-1:0]   lt_idx;
  logic [lhtf_pkg::DEPTH_W-1:0] depth_dec;
  logic [7:0]                   sgr;

  // Mode match on the first two letters
  always_comb begin
    sgr = lhtf_pkg::CH_NUL;
    if (letters_q[0] == lhtf_pkg::CH_LC_T && letters_q[1] == lhtf_pkg::CH_LC_T) begin
      sgr = lhtf_pkg::SGR_UNDERLINE;
    end
    if ((letters_q[0] == lhtf_pkg::CH_LC_E && letters_q[1] == lhtf_pkg::CH_LC_M) ||
        (letters_q[0] == lhtf_pkg::CH_LC_I && letters_q[1] == lhtf_pkg::CH_LC_T)) begin
      sgr = lhtf_pkg::SGR_REVERSE;
    end
    if (letters_q[0] == lhtf_pkg::CH_LC_B && letters_q[1] == lhtf_pkg::CH_LC_F) begin
      sgr = lhtf_pkg::SGR_BOLD;
    end
  end

  assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;

  always_comb begin
    inside_d = inside_q;
    depth_d  = depth_q;
    cmd_d    = cmd_q;
    kanji_d  = kanji_q;
    tail_d   = tail_q;
    brk_d    = brk_q;
    emph_d   = emph_q;
    len_d    = len_q;
    lt_we    = 1'b0;
    op_d     = OP_NONE;
    arg_d    = in_byte_i;

    if (!inside_q) begin
      if (in_byte_i == lhtf_pkg::CH_LBRACE) begin
        inside_d = 1'b1;
        depth_d  = lhtf_pkg::DEPTH_W'(1);
        cmd_d    = 1'b0;
        kanji_d  = 1'b0;
        tail_d   = 2'd0;
        brk_d    = 1'b0;
        emph_d   = 1'b0;
        len_d    = '0;
      end
    end else if (kanji_q) begin
      op_d = OP_ONE;
      if (tail_q != 2'd0) begin
        tail_d = tail_q - 2'd1;
        if (tail_q == 2'd1) kanji_d = 1'b0;
      end else if (in_byte_i == lhtf_pkg::CH_ESC) begin
        tail_d = 2'd2;
      end
    end else if (cmd_q) begin
      case (in_byte_i)
        lhtf_pkg::CH_GT: begin
          op_d  = OP_SPACE3;
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_EQUAL, lhtf_pkg::CH_DOLLAR: begin
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_AMP, lhtf_pkg::CH_HASH: begin
          op_d  = OP_ONE;
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_BSLASH: begin
          op_d  = OP_ONE;
          arg_d = lhtf_pkg::CH_LF;
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_SPACE: begin
          if (len_q >= lhtf_pkg::LEN_W'(2) && sgr != lhtf_pkg::CH_NUL) begin
            op_d   = OP_SGR;
            arg_d  = sgr;
            emph_d = 1'b1;
          end
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_RBRACE: begin
          if (len_q == '0) op_d = OP_ONE;
          cmd_d = 1'b0;
        end
        lhtf_pkg::CH_LBRACK: begin
          len_d = '0;
        end
        lhtf_pkg::CH_LBRACE: begin
          if (len_q == '0) begin
            op_d  = OP_ONE;
            cmd_d = 1'b0;
          end else begin
            len_d = '0;
          end
        end
        lhtf_pkg::CH_RBRACK: begin
          op_d  = OP_BRACKET;
          cmd_d = 1'b0;
          brk_d = 1'b1;
        end
        default: begin
          if (len_q < lhtf_pkg::LEN_W'(lhtf_pkg::CMD_CHARS)) begin
            lt_we = 1'b1;
            len_d = len_q + 1'b1;
          end
        end
      endcase
    end else begin
      case (in_byte_i)
        lhtf_pkg::CH_DOLLAR: begin
        end
        lhtf_pkg::CH_BSLASH: begin
          cmd_d = 1'b1;
          len_d = '0;
        end
        lhtf_pkg::CH_LBRACE: begin
          if (depth_q < lhtf_pkg::DEPTH_W'(lhtf_pkg::MAX_BRACE_DEPTH)) begin
            depth_d = depth_q + 1'b1;
          end
        end
        lhtf_pkg::CH_RBRACE: begin
          if (depth_dec == '0) begin
            // entry closes: rearm and seek the next open brace
            op_d     = emph_q ? OP_END_TERM : OP_TERM;
            inside_d = 1'b0;
            depth_d  = lhtf_pkg::DEPTH_W'(1);
            cmd_d    = 1'b0;
            kanji_d  = 1'b0;
            tail_d   = 2'd0;
            brk_d    = 1'b0;
            emph_d   = 1'b0;
            len_d    = '0;
          end else begin
            if (emph_q) op_d = OP_END;
            emph_d  = 1'b0;
            depth_d = depth_dec;
          end
        end
        lhtf_pkg::CH_LF: begin
          op_d  = OP_ONE;
          arg_d = brk_q ? lhtf_pkg::CH_LF : lhtf_pkg::CH_SPACE;
          brk_d = 1'b0;
        end
        lhtf_pkg::CH_ESC: begin
          op_d    = OP_ONE;
          kanji_d = 1'b1;
        end
        default: begin
          op_d = OP_ONE;
        end
      endcase
    end
  end

  always_comb begin
    case (op_d)
      OP_ONE, OP_TERM:     cnt_d = lhtf_pkg::CNT_W'(1);
      OP_SPACE3, OP_END:   cnt_d = lhtf_pkg::CNT_W'(3);
      OP_SGR, OP_END_TERM: cnt_d = lhtf_pkg::CNT_W'(4);
      OP_BRACKET:          cnt_d = lhtf_pkg::CNT_W'(4) + lhtf_pkg::CNT_W'(len_q);
      default:             cnt_d = '0;
    endcase
  end

  assign sts_o.emits = (cnt_d != '0);
  assign sts_o.last  = (idx_q == cnt_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      depth_q  <= lhtf_pkg::DEPTH_W'(1);
      cmd_q    <= 1'b0;
      kanji_q  <= 1'b0;
      tail_q   <= 2'd0;
      brk_q    <= 1'b0;
      emph_q   <= 1'b0;
      len_q    <= '0;
      op_q     <= OP_NONE;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else if (cmd_i.load) begin
      inside_q <= inside_d;
      depth_q  <= depth_d;
      cmd_q    <= cmd_d;
      kanji_q  <= kanji_d;
      tail_q   <= tail_d;
      brk_q    <= brk_d;
      emph_q   <= emph_d;
      len_q    <= len_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
      idx_q    <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) arg_q <= arg_d;
    if (cmd_i.load && lt_we) letters_q[len_q[lhtf_pkg::LIDX_W-1:0]] <= in_byte_i;
  end

  // Byte select for the current run position
  assign lt_idx = idx_q - lhtf_pkg::CNT_W'(4);

  always_comb begin
    case (op_q)
      OP_ONE:    out_byte_o = arg_q;
      OP_TERM:   out_byte_o = lhtf_pkg::CH_NUL;
      OP_SPACE3: out_byte_o = lhtf_pkg::CH_SPACE;
      OP_SGR, OP_END, OP_END_TERM: begin
        case (idx_q)
          lhtf_pkg::CNT_W'(0): out_byte_o = lhtf_pkg::CH_ESC;
          lhtf_pkg::CNT_W'(1): out_byte_o = lhtf_pkg::CH_LBRACK;
          lhtf_pkg::CNT_W'(2):
            out_byte_o = (op_q == OP_SGR) ? arg_q : lhtf_pkg::SGR_FINAL;
          lhtf_pkg::CNT_W'(3):
            out_byte_o = (op_q == OP_SGR) ? lhtf_pkg::SGR_FINAL : lhtf_pkg::CH_NUL;
          default: out_byte_o = lhtf_pkg::CH_NUL;
        endcase
      end
      OP_BRACKET: begin
        out_byte_o = (idx_q < lhtf_pkg::CNT_W'(4)) ? lhtf_pkg::CH_SPACE :
                     letters_q[lt_idx[lhtf_pkg::LIDX_W-1:0]];
      end
      default: out_byte_o = lhtf_pkg::CH_NUL;
    endcase
  end

  assign last_of_run_o = sts_o.last;
  assign end_of_text_o = sts_o.last && (op_q == OP_TERM || op_q == OP_END_TERM);

endmodule
